// File: sv/rri_pkg.sv
// rri_pkg: widths, stage counts, register codes and angle constants of the
// lidar range-image index unit; shared by the channel interfaces, the cordic
// cell and the top level
package rri_pkg;

	// field widths
	localparam int COORD_W  = 20;
	localparam int ANGLE_W  = 17;
	localparam int RCNT_W   = 8;
	localparam int CCNT_W   = 13;
	localparam int RANGE_W  = 20;
	localparam int ROW_W    = 7;
	localparam int COL_W    = 12;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	// parameter defaults
	localparam int MAX_RINGS_DEF   = 128;
	localparam int MAX_COLUMNS_DEF = 4096;

	// square root chains: planar radicand is (x^2 + y^2) * 2^20, range is x^2 + y^2 + z^2
	localparam int SQ_V_W     = 60;
	localparam int SQ_V_STEPS = SQ_V_W / 2;
	localparam int SQ_R_W     = 40;
	localparam int SQ_R_STEPS = SQ_R_W / 2;

	// cordic chain
	localparam int CORDIC_W     = 43;
	localparam int ACC_W        = 30;
	localparam int CORDIC_STEPS = 24;
	localparam int DEG90_FINE   = 94371840;
	localparam int DEG90        = 92160;
	localparam int ROUND_HALF   = 512;
	localparam int FINE_SHIFT   = 10;

	// atan(2^-i) in 2^-20 degree
	localparam int ATAN_FINE [CORDIC_STEPS] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	// divider chains
	localparam int DIV_N = 21;
	localparam int DIV_W = 18;

	// register map
	typedef enum logic [2:0] {
		REG_BOTTOM_ANGLE = 3'd0,
		REG_VERT_RES     = 3'd1,
		REG_HORIZ_RES    = 3'd2,
		REG_RING_COUNT   = 3'd3,
		REG_COLUMN_COUNT = 3'd4,
		REG_MIN_RANGE    = 3'd5
	} reg_idx_t;

	// cordic start state after the quadrant pre-rotation
	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [ACC_W-1:0]    acc;
		logic                       zero;
	} cordic_pre_t;

endpackage

// File: sv/rri_if.sv
// rri_if: valid/ready channels for point words and index words
// depends on rri_pkg
interface rri_point_if;
	logic                                valid;
	logic                                ready;
	logic signed [rri_pkg::COORD_W-1:0] x_coord;
	logic signed [rri_pkg::COORD_W-1:0] y_coord;
	logic signed [rri_pkg::COORD_W-1:0] z_coord;
	modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
	modport sink   (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

interface rri_index_if;
	logic                          valid;
	logic                          ready;
	logic                          point_valid;
	logic [rri_pkg::ROW_W-1:0]     image_row;
	logic [rri_pkg::COL_W-1:0]     column_index;
	logic [rri_pkg::RANGE_W-1:0]   point_range;
	modport source (output valid, output point_valid, output image_row, output column_index,
		output point_range, input ready);
	modport sink   (input valid, input point_valid, input image_row, input column_index,
		input point_range, output ready);
endinterface

// File: sv/lidar_point_to_range_image_index_unit.sv
// lidar_point_to_range_image_index_unit: projects a lidar point onto a range image
// depends on rri_pkg, rri_if, rri_sqrt_cell, rri_cordic_cell, rri_div_cell
//
// Usage
//   pt  : point words (x, y, z, signed 1/256 m), taken when valid and ready are high
//   idx : index words (point_valid, image_row, column_index, point_range)
//   APB : six registers at byte addresses 0, 4, .. 20; pready is always high,
//         write registers only while no point is in flight
// Timing
//   One point per cycle sustained unless the receiver stalls.
//   A point passes through the chains of cells: a squaring stage, a summing
//   stage, 30 square root cells, a pre-rotation stage, 24 cordic cells, a
//   rounding stage, 21 divider cells, then the output register.
//   The whole chain advances together: when the receiver stalls with a word
//   waiting, pt.ready drops and every stage holds; empty slots do not stop it.
// Reset
//   arst_n clears the slot valid bits and loads the register defaults; no
//   clearing pass is needed.
module lidar_point_to_range_image_index_unit #(
	parameter int MAX_RINGS   = rri_pkg::MAX_RINGS_DEF,
	parameter int MAX_COLUMNS = rri_pkg::MAX_COLUMNS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rri_point_if.sink                  pt,
	rri_index_if.source                idx,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rri_pkg::APB_AW-1:0] paddr,
	input  logic [rri_pkg::APB_DW-1:0] pwdata,
	output logic [rri_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	localparam int CW    = rri_pkg::CORDIC_W;
	localparam int AW    = rri_pkg::ACC_W;
	localparam int VS    = rri_pkg::SQ_V_STEPS;
	localparam int RS    = rri_pkg::SQ_R_STEPS;
	localparam int CS    = rri_pkg::CORDIC_STEPS;
	localparam int DN    = rri_pkg::DIV_N;
	localparam int DW    = rri_pkg::DIV_W;
	localparam int LAT   = 2 + VS + 1 + CS + 1 + DN + 1;
	localparam int RNW   = $clog2(MAX_RINGS + 1);
	localparam int CNW   = $clog2(MAX_COLUMNS + 1);

	typedef struct packed {
		logic signed [rri_pkg::COORD_W-1:0] x;
		logic signed [rri_pkg::COORD_W-1:0] y;
		logic signed [rri_pkg::COORD_W-1:0] z;
	} xyz_t;

	typedef struct packed {
		logic                        vzero;
		logic                        hzero;
		logic [rri_pkg::RANGE_W-1:0] range;
	} cside_t;

	typedef struct packed {
		logic                        vneg;
		logic                        dneg;
		logic [rri_pkg::RANGE_W-1:0] range;
	} dside_t;

	// configuration registers
	logic [rri_pkg::ANGLE_W-1:0] bottom_q;
	logic [rri_pkg::ANGLE_W-1:0] vres_q;
	logic [rri_pkg::ANGLE_W-1:0] hres_q;
	logic [rri_pkg::RCNT_W-1:0]  rcnt_q;
	logic [rri_pkg::CCNT_W-1:0]  ccnt_q;
	logic [rri_pkg::RANGE_W-1:0] minr_q;

	logic                        cfg_wr;
	logic                        adv;
	logic [LAT-1:0]              vld_q;

	// apb write and read
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_q <= 17'd25498;
			vres_q   <= 17'd437;
			hres_q   <= 17'd205;
			rcnt_q   <= 8'd64;
			ccnt_q   <= 13'd1800;
			minr_q   <= 20'd256;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				rri_pkg::REG_BOTTOM_ANGLE: bottom_q <= pwdata[16:0];
				rri_pkg::REG_VERT_RES:     vres_q   <= pwdata[16:0];
				rri_pkg::REG_HORIZ_RES:    hres_q   <= pwdata[16:0];
				rri_pkg::REG_RING_COUNT:   rcnt_q   <= pwdata[7:0];
				rri_pkg::REG_COLUMN_COUNT: ccnt_q   <= pwdata[12:0];
				rri_pkg::REG_MIN_RANGE:    minr_q   <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			rri_pkg::REG_BOTTOM_ANGLE: prdata = 32'(bottom_q);
			rri_pkg::REG_VERT_RES:     prdata = 32'(vres_q);
			rri_pkg::REG_HORIZ_RES:    prdata = 32'(hres_q);
			rri_pkg::REG_RING_COUNT:   prdata = 32'(rcnt_q);
			rri_pkg::REG_COLUMN_COUNT: prdata = 32'(ccnt_q);
			rri_pkg::REG_MIN_RANGE:    prdata = 32'(minr_q);
			default:                   prdata = '0;
		endcase
	end

	// effective settings: zero resolution acts as one, counts clamp to the maxima
	logic [rri_pkg::ANGLE_W-1:0] resy;
	logic [rri_pkg::ANGLE_W-1:0] resx;
	logic [RNW-1:0]              rings;
	logic [CNW-1:0]              cols;
	logic [DW-1:0]               div_v;
	logic [DW-1:0]               div_h;

	assign resy  = (vres_q == '0) ? rri_pkg::ANGLE_W'(1) : vres_q;
	assign resx  = (hres_q == '0) ? rri_pkg::ANGLE_W'(1) : hres_q;
	assign rings = (32'(rcnt_q) > MAX_RINGS) ? RNW'(MAX_RINGS) : RNW'(rcnt_q);
	assign cols  = (32'(ccnt_q) > MAX_COLUMNS) ? CNW'(MAX_COLUMNS) : CNW'(ccnt_q);
	assign div_v = DW'(resy);
	assign div_h = DW'({resx, 1'b0});

	// chain control: all stages move together
	assign adv      = !vld_q[LAT-1] || idx.ready;
	assign pt.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], pt.valid};
		end
	end

	// stage 1: squares
	logic signed [39:0] xe;
	logic signed [39:0] ye;
	logic signed [39:0] ze;
	xyz_t               p_s1;
	xyz_t               p_s2;
	logic [38:0]        x2_s1;
	logic [38:0]        y2_s1;
	logic [38:0]        z2_s1;
	logic [39:0]        sxy_s2;
	logic [39:0]        sxyz_s2;

	assign xe = 40'(pt.x_coord);
	assign ye = 40'(pt.y_coord);
	assign ze = 40'(pt.z_coord);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1    <= '{x: pt.x_coord, y: pt.y_coord, z: pt.z_coord};
			x2_s1   <= 39'(xe * xe);
			y2_s1   <= 39'(ye * ye);
			z2_s1   <= 39'(ze * ze);
			// stage 2: sums of squares
			p_s2    <= p_s1;
			sxy_s2  <= 40'(x2_s1) + 40'(y2_s1);
			sxyz_s2 <= 40'(x2_s1) + 40'(y2_s1) + 40'(z2_s1);
		end
	end

	// square root chains
	logic [rri_pkg::SQ_V_W-1:0] vn [VS+1];
	logic [rri_pkg::SQ_V_W-1:0] vr [VS+1];
	logic [rri_pkg::SQ_R_W-1:0] rn [RS+1];
	logic [rri_pkg::SQ_R_W-1:0] rr [RS+1];

	assign vn[0] = {sxy_s2, 20'b0};
	assign vr[0] = '0;
	assign rn[0] = sxyz_s2;
	assign rr[0] = '0;

	for (genvar k = 0; k < VS; k++) begin : g_sqv
		rri_sqrt_cell #(.W(rri_pkg::SQ_V_W), .STEP(k)) u_cell (
			.clk (clk), .en (adv),
			.n_i (vn[k]), .r_i (vr[k]), .n_o (vn[k+1]), .r_o (vr[k+1])
		);
	end

	for (genvar k = 0; k < RS; k++) begin : g_sqr
		rri_sqrt_cell #(.W(rri_pkg::SQ_R_W), .STEP(k)) u_cell (
			.clk (clk), .en (adv),
			.n_i (rn[k]), .r_i (rr[k]), .n_o (rn[k+1]), .r_o (rr[k+1])
		);
	end

	// coordinates and range ride alongside the roots
	xyz_t                        sd_q  [1:VS];
	logic [rri_pkg::RANGE_W-1:0] rng_q [RS+1:VS];

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_q[1] <= p_s2;
			for (int k = 1; k < VS; k++) begin
				sd_q[k+1] <= sd_q[k];
			end
			rng_q[RS+1] <= rr[RS][rri_pkg::RANGE_W-1:0];
			for (int k = RS + 1; k < VS; k++) begin
				rng_q[k+1] <= rng_q[k];
			end
		end
	end

	// quadrant pre-rotation into the right half plane
	function automatic rri_pkg::cordic_pre_t prerotate(logic signed [CW-1:0] vx,
		logic signed [CW-1:0] vy);
		rri_pkg::cordic_pre_t s;
		s.x    = vx;
		s.y    = vy;
		s.acc  = '0;
		s.zero = 1'b0;
		if (vx == '0 && vy == '0) begin
			s.zero = 1'b1;
		end else if (vx < 0) begin
			if (vy >= 0) begin
				s.x   = vy;
				s.y   = -vx;
				s.acc = AW'(rri_pkg::DEG90_FINE);
			end else begin
				s.x   = -vy;
				s.y   = vx;
				s.acc = -AW'(rri_pkg::DEG90_FINE);
			end
		end
		return s;
	endfunction

	logic signed [CW-1:0]  vx0;
	logic signed [CW-1:0]  vy0;
	logic signed [CW-1:0]  hx0;
	logic signed [CW-1:0]  hy0;
	rri_pkg::cordic_pre_t  vpre_s;
	rri_pkg::cordic_pre_t  hpre_s;
	logic [rri_pkg::RANGE_W-1:0] rpre_s;

	assign vx0 = signed'(CW'({vr[VS][29:0], 10'b0}));
	assign vy0 = CW'(sd_q[VS].z) <<< 20;
	assign hx0 = CW'(sd_q[VS].y) <<< 20;
	assign hy0 = CW'(sd_q[VS].x) <<< 20;

	always_ff @(posedge clk) begin
		if (adv) begin
			vpre_s <= prerotate(vx0, vy0);
			hpre_s <= prerotate(hx0, hy0);
			rpre_s <= rng_q[VS];
		end
	end

	// cordic chains, vertical and horizontal
	logic signed [CW-1:0] vcx [CS+1];
	logic signed [CW-1:0] vcy [CS+1];
	logic signed [AW-1:0] vca [CS+1];
	logic signed [CW-1:0] hcx [CS+1];
	logic signed [CW-1:0] hcy [CS+1];
	logic signed [AW-1:0] hca [CS+1];

	assign vcx[0] = vpre_s.x;
	assign vcy[0] = vpre_s.y;
	assign vca[0] = vpre_s.acc;
	assign hcx[0] = hpre_s.x;
	assign hcy[0] = hpre_s.y;
	assign hca[0] = hpre_s.acc;

	for (genvar k = 0; k < CS; k++) begin : g_cor
		rri_cordic_cell #(.W(CW), .AW(AW), .STEP(k)) u_vcell (
			.clk (clk), .en (adv),
			.x_i (vcx[k]), .y_i (vcy[k]), .a_i (vca[k]),
			.x_o (vcx[k+1]), .y_o (vcy[k+1]), .a_o (vca[k+1])
		);
		rri_cordic_cell #(.W(CW), .AW(AW), .STEP(k)) u_hcell (
			.clk (clk), .en (adv),
			.x_i (hcx[k]), .y_i (hcy[k]), .a_i (hca[k]),
			.x_o (hcx[k+1]), .y_o (hcy[k+1]), .a_o (hca[k+1])
		);
	end

	cside_t cs_q [1:CS];

	always_ff @(posedge clk) begin
		if (adv) begin
			cs_q[1] <= '{vzero: vpre_s.zero, hzero: hpre_s.zero, range: rpre_s};
			for (int k = 1; k < CS; k++) begin
				cs_q[k+1] <= cs_q[k];
			end
		end
	end

	// rounding to 1/1024 degree, ring and column dividends
	logic signed [AW-1:0] vrnd;
	logic signed [AW-1:0] hrnd;
	logic signed [21:0]   vang;
	logic signed [21:0]   hang;
	logic signed [21:0]   vsum;
	logic signed [21:0]   dang;
	logic [21:0]          dmag;
	logic [DN-1:0]        numv_s;
	logic [DN-1:0]        numh_s;
	dside_t               ang_s;

	assign vrnd = (vca[CS] + AW'(rri_pkg::ROUND_HALF)) >>> rri_pkg::FINE_SHIFT;
	assign hrnd = (hca[CS] + AW'(rri_pkg::ROUND_HALF)) >>> rri_pkg::FINE_SHIFT;
	assign vang = cs_q[CS].vzero ? '0 : 22'(vrnd);
	assign hang = cs_q[CS].hzero ? '0 : 22'(hrnd);
	assign vsum = vang + 22'(signed'({1'b0, bottom_q}));
	assign dang = hang - 22'(rri_pkg::DEG90);
	assign dmag = dang[21] ? 22'(-dang) : 22'(dang);

	always_ff @(posedge clk) begin
		if (adv) begin
			numv_s <= vsum[21] ? '0 : DN'(vsum);
			numh_s <= DN'({dmag, 1'b0}) + DN'(resx);
			ang_s  <= '{vneg: vsum[21], dneg: dang[21], range: cs_q[CS].range};
		end
	end

	// divider chains: ring = vsum / resy, column step = rounded d / resx
	logic [DW-1:0] dvr [DN+1];
	logic [DN-1:0] dvn [DN+1];
	logic [DN-1:0] dvq [DN+1];
	logic [DW-1:0] dhr [DN+1];
	logic [DN-1:0] dhn [DN+1];
	logic [DN-1:0] dhq [DN+1];

	assign dvr[0] = '0;
	assign dvn[0] = numv_s;
	assign dvq[0] = '0;
	assign dhr[0] = '0;
	assign dhn[0] = numh_s;
	assign dhq[0] = '0;

	for (genvar k = 0; k < DN; k++) begin : g_div
		rri_div_cell #(.NW(DN), .DW(DW)) u_vcell (
			.clk (clk), .en (adv), .div_i (div_v),
			.rem_i (dvr[k]), .num_i (dvn[k]), .quo_i (dvq[k]),
			.rem_o (dvr[k+1]), .num_o (dvn[k+1]), .quo_o (dvq[k+1])
		);
		rri_div_cell #(.NW(DN), .DW(DW)) u_hcell (
			.clk (clk), .en (adv), .div_i (div_h),
			.rem_i (dhr[k]), .num_i (dhn[k]), .quo_i (dhq[k]),
			.rem_o (dhr[k+1]), .num_o (dhn[k+1]), .quo_o (dhq[k+1])
		);
	end

	dside_t ds_q [1:DN];

	always_ff @(posedge clk) begin
		if (adv) begin
			ds_q[1] <= ang_s;
			for (int k = 1; k < DN; k++) begin
				ds_q[k+1] <= ds_q[k];
			end
		end
	end

	// column centring with one wrap, checks, output register
	logic signed [23:0] half;
	logic signed [23:0] cols_s;
	logic signed [23:0] col_c;
	logic signed [23:0] col_w;
	logic [31:0]        row_w;
	logic               ok;
	logic               pv_q;
	logic [rri_pkg::ROW_W-1:0]   row_q;
	logic [rri_pkg::COL_W-1:0]   col_q;
	logic [rri_pkg::RANGE_W-1:0] range_q;

	assign half   = signed'(24'(cols >> 1));
	assign cols_s = signed'(24'(cols));
	assign col_c  = ds_q[DN].dneg ? half + signed'(24'(dhq[DN])) : half - signed'(24'(dhq[DN]));
	assign col_w  = (col_c >= cols_s) ? col_c - cols_s : col_c;
	assign row_w  = 32'(rings) - 32'(dvq[DN]) - 32'd1;
	assign ok     = !ds_q[DN].vneg && (32'(dvq[DN]) < 32'(rings))
		&& !col_w[23] && (col_w < cols_s) && (ds_q[DN].range >= minr_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			pv_q    <= ok;
			row_q   <= ok ? rri_pkg::ROW_W'(row_w) : '0;
			col_q   <= ok ? rri_pkg::COL_W'(col_w) : '0;
			range_q <= ds_q[DN].range;
		end
	end

	assign idx.valid        = vld_q[LAT-1];
	assign idx.point_valid  = pv_q;
	assign idx.image_row    = row_q;
	assign idx.column_index = col_q;
	assign idx.point_range  = range_q;

	// checks
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		pt.ready == (!idx.valid || idx.ready))
		else $error("input ready does not follow the output stall");

	a_accept_enters_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(pt.valid && pt.ready) |=> vld_q[0])
		else $error("accepted word missing from first stage");

	a_invalid_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		(idx.valid && !idx.point_valid) |-> (idx.image_row == '0 && idx.column_index == '0))
		else $error("rejected point carries a non-zero index");

	a_valid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(idx.valid && idx.point_valid) |-> (idx.point_range >= minr_q))
		else $error("point nearer than minimum range marked valid");

endmodule

// File: sv/rri_sqrt_cell.sv
// rri_sqrt_cell: one bit of a restoring integer square root, registered
// no package dependency; W even, STEP counts from the top bit pair
module rri_sqrt_cell #(
	parameter int W    = 40,
	parameter int STEP = 0
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] n_i,
	input  logic [W-1:0] r_i,
	output logic [W-1:0] n_o,
	output logic [W-1:0] r_o
);

	localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * STEP);

	logic [W:0] trial;

	// trial subtrahend for this bit pair
	assign trial = {1'b0, r_i} + {1'b0, BIT};

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, n_i} >= trial) begin
				n_o <= n_i - trial[W-1:0];
				r_o <= (r_i >> 1) + BIT;
			end else begin
				n_o <= n_i;
				r_o <= r_i >> 1;
			end
		end
	end

endmodule

// File: sv/rri_cordic_cell.sv
// rri_cordic_cell: one vectoring micro-rotation, registered
// depends on rri_pkg for the arctangent table
module rri_cordic_cell #(
	parameter int W    = rri_pkg::CORDIC_W,
	parameter int AW   = rri_pkg::ACC_W,
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [W-1:0]  x_i,
	input  logic signed [W-1:0]  y_i,
	input  logic signed [AW-1:0] a_i,
	output logic signed [W-1:0]  x_o,
	output logic signed [W-1:0]  y_o,
	output logic signed [AW-1:0] a_o
);

	localparam logic signed [AW-1:0] ANG = AW'(rri_pkg::ATAN_FINE[STEP]);

	logic signed [W-1:0] dx;
	logic signed [W-1:0] dy;

	// floor shifts of the cross terms
	assign dx = y_i >>> STEP;
	assign dy = x_i >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_i[W-1]) begin
				x_o <= x_i + dx;
				y_o <= y_i - dy;
				a_o <= a_i + ANG;
			end else begin
				x_o <= x_i - dx;
				y_o <= y_i + dy;
				a_o <= a_i - ANG;
			end
		end
	end

endmodule

// File: sv/rri_div_cell.sv
// rri_div_cell: one quotient bit of a restoring unsigned divider, registered
// no package dependency; divisor must be non-zero
module rri_div_cell #(
	parameter int NW = 21,
	parameter int DW = 18
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] div_i,
	input  logic [DW-1:0] rem_i,
	input  logic [NW-1:0] num_i,
	input  logic [NW-1:0] quo_i,
	output logic [DW-1:0] rem_o,
	output logic [NW-1:0] num_o,
	output logic [NW-1:0] quo_o
);

	logic [DW:0] part;

	// bring down the next dividend bit
	assign part = {rem_i, num_i[NW-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			num_o <= num_i << 1;
			if (part >= {1'b0, div_i}) begin
				rem_o <= DW'(part - {1'b0, div_i});
				quo_o <= {quo_i[NW-2:0], 1'b1};
			end else begin
				rem_o <= part[DW-1:0];
				quo_o <= {quo_i[NW-2:0], 1'b0};
			end
		end
	end

endmodule
